/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the sorted table engine.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/ste_pkg.sv */
// Types and codes shared by the sorted table engine core and its cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ste_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT     = 3'd0,
    REQ_FIND       = 3'd1,
    REQ_REMOVE_KEY = 3'd2,
    REQ_REMOVE_IDX = 3'd3,
    REQ_GET_IDX    = 3'd4,
    REQ_TRUNCATE   = 3'd5
  } req_code_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY
  } ste_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     signed_mode;
  } cell_cmd_t;

  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_flags_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] key;
    logic [6:0]  index;
  } ste_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] data;
    logic [5:0]  position;
    logic [6:0]  count;
  } ste_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/ste_cell.sv */
// One slot of the sorted table: holds a key, compares it against the
// request key and shifts with its neighbors. Depends on ste_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ste_cell #(
  parameter int INDEX     = 0,
  parameter int KEY_WIDTH = 32,
  parameter int POS_W     = 6
) (
  input  wire                   clk,
  input  ste_pkg::cell_cmd_t    cmd,
  input  wire [POS_W-1:0]       pos,
  input  wire [KEY_WIDTH-1:0]   key,
  input  wire [KEY_WIDTH-1:0]   left_value,
  input  wire [KEY_WIDTH-1:0]   right_value,
  output logic [KEY_WIDTH-1:0]  value,
  output ste_pkg::cmp_flags_t   flags
);

  import ste_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

  logic [KEY_WIDTH-1:0] sign_flip;
  logic [KEY_WIDTH-1:0] own_ord;
  logic [KEY_WIDTH-1:0] key_ord;

  // Flip the sign bit so signed order becomes unsigned order.
  assign sign_flip = KEY_WIDTH'(cmd.signed_mode) << (KEY_WIDTH - 1);
  assign own_ord   = value ^ sign_flip;
  assign key_ord   = key ^ sign_flip;

  assign flags.lt = own_ord < key_ord;
  assign flags.gt = own_ord > key_ord;

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INSERT: begin
        if (MY_POS > pos) begin
          value <= left_value;
        end else if (MY_POS == pos) begin
          value <= key;
        end
      end
      CELL_DELETE: begin
        if (MY_POS >= pos) begin
          value <= right_value;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/sorted_table_engine_core.sv */
// Top level of the sorted table engine: request sequencer and cell chain.
// Depends on ste_pkg, ste_cell and assert_macros.svh.
//
// Usage:
//   A request beat (req) is taken at a rising edge with start high and busy
//   low. Exactly one result beat follows on rsp, marked by done for one
//   cycle; the receiver cannot stall it and must take it in that cycle.
//   Get, remove by index and truncate go from acceptance to ST_APPLY, and
//   done is registered from ST_APPLY. Insert, find and remove by key run a
//   binary search in ST_SEARCH, one probe per cycle, until an equal entry
//   is hit or the range is empty, then pass through ST_APPLY to done.
//   busy drops in the cycle that done is high, so the next request can be
//   taken then. Every cell compares its key with the request key at once;
//   the insert or remove shift moves every cell of the chain together.
//   compare_mode is written by cfg_we/cfg_wdata; the user must write it
//   only while idle, as the block itself does not enforce this.
//   Reset clears the entry count, compare_mode and the sequencer; entry
//   contents stay as they were and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sorted_table_engine_core #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  ste_pkg::ste_req_t   req,
  output logic                done,
  output ste_pkg::ste_rsp_t   rsp,
  input  wire                 cfg_we,
  input  wire                 cfg_wdata
);

  import ste_pkg::*;

  localparam int POS_W = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int IW    = (CW > 7) ? CW : 7;

  ste_state_t           state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        lo, lo_next;
  logic [CW-1:0]        hi_p1, hi_p1_next;
  logic [CW-1:0]        where, where_next;
  logic                 hit, hit_next;
  logic                 compare_mode;
  logic [2:0]           req_type;
  logic [KEY_WIDTH-1:0] req_key;
  logic [IW-1:0]        req_idx;
  ste_rsp_t             rsp_r, rsp_next;
  logic                 done_next;

  cell_cmd_t            cmd;
  logic [POS_W-1:0]     cell_pos;
  logic [KEY_WIDTH-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]  lt_vec;
  logic [CAPACITY-1:0]  gt_vec;

  logic [CW-1:0]        span;
  logic [CW-1:0]        mid;
  logic [POS_W-1:0]     mid_idx;
  logic [63:0]          key_in_wide;
  logic [63:0]          key_wide;
  logic [63:0]          rd_wide;
  logic [KEY_WIDTH-1:0] rd_value;
  logic [IW-1:0]        count_ext;
  logic [IW-1:0]        count_next_ext;
  logic [IW-1:0]        where_ext;

  // Cell chain
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [KEY_WIDTH-1:0] left_v;
      logic [KEY_WIDTH-1:0] right_v;
      cmp_flags_t           fl;

      if (g == 0) begin : g_first
        assign left_v = req_key;
      end else begin : g_left
        assign left_v = cell_value[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
        assign right_v = cell_value[g];
      end else begin : g_right
        assign right_v = cell_value[g+1];
      end

      ste_cell #(
        .INDEX     (g),
        .KEY_WIDTH (KEY_WIDTH),
        .POS_W     (POS_W)
      ) u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .pos         (cell_pos),
        .key         (req_key),
        .left_value  (left_v),
        .right_value (right_v),
        .value       (cell_value[g]),
        .flags       (fl)
      );

      assign lt_vec[g] = fl.lt;
      assign gt_vec[g] = fl.gt;
    end
  endgenerate

  // Binary search probe; valid only while lo < hi_p1.
  assign span    = hi_p1 - lo - 1'b1;
  assign mid     = lo + (span >> 1);
  assign mid_idx = mid[POS_W-1:0];

  assign key_in_wide    = {32'd0, req.key};
  assign key_wide       = 64'(req_key);
  assign rd_value       = cell_value[req_idx[POS_W-1:0]];
  assign rd_wide        = 64'(rd_value);
  assign count_ext      = IW'(count);
  assign count_next_ext = IW'(count_next);
  assign where_ext      = IW'(where);

  always_comb begin
    state_next      = state;
    lo_next         = lo;
    hi_p1_next      = hi_p1;
    where_next      = where;
    hit_next        = hit;
    count_next      = count;
    done_next       = 1'b0;
    rsp_next        = rsp_r;
    cmd.op          = CELL_HOLD;
    cmd.signed_mode = compare_mode;
    cell_pos        = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          lo_next    = '0;
          hi_p1_next = count;
          hit_next   = 1'b0;
          where_next = '0;
          if (req.req_type inside {REQ_INSERT, REQ_FIND, REQ_REMOVE_KEY}) begin
            state_next = ST_SEARCH;
          end else begin
            state_next = ST_APPLY;
          end
        end
      end
      ST_SEARCH: begin
        if (lo < hi_p1) begin
          if (lt_vec[mid_idx]) begin
            lo_next = mid + 1'b1;
          end else if (gt_vec[mid_idx]) begin
            hi_p1_next = mid;
          end else begin
            // stop on the equal entry the probe landed on
            hit_next   = 1'b1;
            where_next = mid;
            state_next = ST_APPLY;
          end
        end else begin
          where_next = lo;
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_next        = ST_IDLE;
        done_next         = 1'b1;
        rsp_next.status   = STATUS_OK;
        rsp_next.found    = 1'b0;
        rsp_next.data     = '0;
        rsp_next.position = '0;
        case (req_type)
          REQ_INSERT: begin
            if (count == CW'(CAPACITY)) begin
              rsp_next.status = STATUS_FULL;
            end else begin
              cmd.op            = CELL_INSERT;
              cell_pos          = where[POS_W-1:0];
              count_next        = count + 1'b1;
              rsp_next.position = where_ext[5:0];
            end
          end
          REQ_FIND, REQ_REMOVE_KEY: begin
            if (hit) begin
              rsp_next.found    = 1'b1;
              rsp_next.data     = key_wide[31:0];
              rsp_next.position = where_ext[5:0];
              if (req_type == REQ_REMOVE_KEY) begin
                cmd.op     = CELL_DELETE;
                cell_pos   = where[POS_W-1:0];
                count_next = count - 1'b1;
              end
            end
          end
          REQ_REMOVE_IDX, REQ_GET_IDX: begin
            if (req_idx >= count_ext) begin
              rsp_next.status = STATUS_RANGE;
            end else begin
              rsp_next.data     = rd_wide[31:0];
              rsp_next.position = req_idx[5:0];
              if (req_type == REQ_REMOVE_IDX) begin
                cmd.op     = CELL_DELETE;
                cell_pos   = req_idx[POS_W-1:0];
                count_next = count - 1'b1;
              end
            end
          end
          REQ_TRUNCATE: begin
            if (req_idx > count_ext) begin
              rsp_next.status = STATUS_RANGE;
            end else begin
              count_next = req_idx[CW-1:0];
            end
          end
          default: begin
          end
        endcase
        rsp_next.count = count_next_ext[6:0];
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      compare_mode <= 1'b0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      if (cfg_we) begin
        compare_mode <= cfg_wdata;
      end
    end
  end

  // Request latch and search registers carry no reset.
  always_ff @(posedge clk) begin
    lo    <= lo_next;
    hi_p1 <= hi_p1_next;
    where <= where_next;
    hit   <= hit_next;
    rsp_r <= rsp_next;
    if (state == ST_IDLE && start) begin
      req_type <= req.req_type;
      req_key  <= key_in_wide[KEY_WIDTH-1:0];
      req_idx  <= IW'(req.index);
    end
  end

  assign busy = (state != ST_IDLE);
  assign rsp  = rsp_r;

  `ASSERT_CLK(a_count_max, clk, rst, count <= CW'(CAPACITY))
  `ASSERT_IMPL(a_done_after_apply, clk, rst, done, $past(state == ST_APPLY))
  `ASSERT_IMPL(a_search_bounds, clk, rst, state == ST_SEARCH, lo <= hi_p1 && hi_p1 <= count)
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPL(a_full_status, clk, rst, done && rsp_r.status == STATUS_FULL, count == CW'(CAPACITY))

endmodule

`default_nettype wire
